// ----- rtl/drp_pkg.sv -----
// Shared types and constants for the display reply and key parser.
// No dependencies; every other file in rtl/ except drp_if.sv uses this package.
`timescale 1ns / 1ps

package drp_pkg;

    // Key frame: 55 id 00 00 FF FF FF
    localparam int unsigned FRAME_LENGTH = 7;
    localparam logic [2:0]  FRAME_LAST   = 3'(FRAME_LENGTH - 1);
    localparam logic [2:0]  POS_ID       = 3'd1;

    localparam logic [7:0] HDR_KEY     = 8'h55;
    localparam logic [7:0] HDR_NUM     = 8'h71;
    localparam logic [7:0] TERM_BYTE   = 8'hFF;
    localparam logic [7:0] FILL_BYTE   = 8'h00;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_THREE = 8'h33;

    // Numeric reply: four payload bytes, then FF FF FF
    localparam logic [2:0] PAYLOAD_BYTES = 3'd4;
    localparam logic [1:0] TERM_LAST     = 2'd2;

    typedef enum logic [1:0] {
        ACT_RX_BYTE     = 2'd0,
        ACT_AWAIT_NUM   = 2'd1,
        ACT_AWAIT_TRANS = 2'd2,
        ACT_ABANDON     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_NONE       = 2'd0,
        KIND_KEY        = 2'd1,
        KIND_NUM_DONE   = 2'd2,
        KIND_TRANS_DONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_START      = 3'd1,
        EV_TOGGLE     = 3'd2,
        EV_FREQ       = 3'd3,
        EV_SET_CYCLES = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_NUM   = 2'd1,
        WAIT_TRANS = 2'd2
    } t_wait;

    // Input request as held in the input register
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
        logic [7:0] reply_code;
    } t_in_req;

    // Reply matcher outcome for one request
    typedef struct packed {
        logic        to_keys;
        t_kind       kind;
        logic [31:0] value;
    } t_match_res;

    // Key parser outcome for one byte
    typedef struct packed {
        t_event     ev;
        logic [1:0] cyc;
    } t_key_res;

endpackage

// ----- rtl/drp_if.sv -----
// Valid/ready channel interfaces for the parser's request and result sides.
// Standalone; widths follow the fixed field widths.
`timescale 1ns / 1ps

interface drp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] reply_code;

    modport source (output valid, output action, output rx_byte, output reply_code,
                    input ready);
    modport sink   (input valid, input action, input rx_byte, input reply_code,
                    output ready);
endinterface

interface drp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  event_code;
    logic [1:0]  cycle_count;
    logic [31:0] reply_value;

    modport source (output valid, output result_kind, output event_code,
                    output cycle_count, output reply_value, input ready);
    modport sink   (input valid, input result_kind, input event_code,
                    input cycle_count, input reply_value, output ready);
endinterface

// ----- rtl/display_reply_and_key_parser.sv -----
// Top level of the display reply and key parser.
// Depends on drp_pkg, drp_if, drp_reply_match and drp_key_parser.
//
// Usage:
//   i_in  carries one request per handshake: action (received byte, arm a
//         numeric wait, arm a transparent wait with reply_code, abandon),
//         rx_byte and reply_code.
//   o_out returns exactly one result per request, in order: result_kind,
//         event_code, cycle_count and reply_value; an all-zero result means
//         nothing completed on that request.
//   Path: a request is held in the input register, then moves into the
//         result register once that register is free or being taken.
//   Throughput: one request per cycle while o_out.ready stays high; the parse
//         is a single compare-and-select pass from the input register to the
//         result register, and parser state updates in the same cycle.
//   Stall: while o_out.ready is low the result register holds; one more
//         request is taken into the input register, then i_in.ready drops
//         until the result is taken.
//   Reset: synchronous, active low; clears both valid flags, the key frame
//         fill, the wait mode and the reply matcher counters. No clearing
//         pass; requests are taken as soon as reset is released.
`timescale 1ns / 1ps

module display_reply_and_key_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drp_in_if.sink    i_in,
    drp_out_if.source o_out
);

    // input register stage
    logic             r_in_valid;
    drp_pkg::t_in_req r_in;

    // result register stage
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [2:0]  r_event;
    logic [1:0]  r_cyc;
    logic [31:0] r_value;

    logic                w_step;      // input register moves into the result register
    drp_pkg::t_match_res w_match;
    drp_pkg::t_key_res   w_key;
    drp_pkg::t_kind      n_kind;
    drp_pkg::t_event     n_event;
    logic [1:0]          n_cyc;

    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action     <= i_in.action;
            r_in.rx_byte    <= i_in.rx_byte;
            r_in.reply_code <= i_in.reply_code;
        end
    end

    drp_reply_match u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_action     (drp_pkg::t_action'(r_in.action)),
        .i_rx_byte    (r_in.rx_byte),
        .i_reply_code (r_in.reply_code),
        .o_res        (w_match)
    );

    // key parser only sees bytes the matcher passes on
    drp_key_parser u_keys (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step && w_match.to_keys),
        .i_rx_byte (r_in.rx_byte),
        .o_res     (w_key)
    );

    always_comb begin
        n_kind  = w_match.kind;
        n_event = drp_pkg::EV_NONE;
        n_cyc   = 2'd0;
        if (w_match.to_keys && w_key.ev != drp_pkg::EV_NONE) begin
            n_kind  = drp_pkg::KIND_KEY;
            n_event = w_key.ev;
            n_cyc   = w_key.cyc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_kind  <= n_kind;
            r_event <= n_event;
            r_cyc   <= n_cyc;
            r_value <= w_match.value;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.event_code  = r_event;
    assign o_out.cycle_count = r_cyc;
    assign o_out.reply_value = r_value;

endmodule

// ----- rtl/drp_key_parser.sv -----
// Key frame and ASCII set-cycles parser; state advances on i_step.
// Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_key_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_rx_byte,
    output drp_pkg::t_key_res o_res
);

    logic [2:0] r_fill, n_fill;
    logic       r_ok,   n_ok;     // fixed bytes seen so far are good
    logic [7:0] r_id,   n_id;

    always_comb begin
        n_fill    = r_fill;
        n_ok      = r_ok;
        n_id      = r_id;
        o_res.ev  = drp_pkg::EV_NONE;
        o_res.cyc = 2'd0;

        if (r_fill == 3'd0) begin
            if (i_rx_byte == drp_pkg::ASCII_ONE || i_rx_byte == drp_pkg::ASCII_THREE) begin
                o_res.ev  = drp_pkg::EV_SET_CYCLES;
                o_res.cyc = i_rx_byte[1:0];   // '1' -> 1, '3' -> 3
            end else if (i_rx_byte == drp_pkg::HDR_KEY) begin
                n_fill = 3'd1;
                n_ok   = 1'b1;
            end
        end else if (i_rx_byte == drp_pkg::HDR_KEY) begin
            // header mid-frame resyncs
            n_fill = 3'd1;
            n_ok   = 1'b1;
        end else if (r_fill == drp_pkg::FRAME_LAST) begin
            n_fill = 3'd0;
            if (r_ok && i_rx_byte == drp_pkg::TERM_BYTE &&
                r_id[7:2] == 6'd0 && r_id[1:0] != 2'd0) begin
                o_res.ev = drp_pkg::t_event'({1'b0, r_id[1:0]});
            end
        end else begin
            n_fill = r_fill + 3'd1;
            case (r_fill) inside
                drp_pkg::POS_ID: n_id = i_rx_byte;
                3'd2, 3'd3:      n_ok = r_ok && (i_rx_byte == drp_pkg::FILL_BYTE);
                3'd4, 3'd5:      n_ok = r_ok && (i_rx_byte == drp_pkg::TERM_BYTE);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
            r_ok   <= 1'b0;
        end else if (i_step) begin
            r_fill <= n_fill;
            r_ok   <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_id <= n_id;
        end
    end

endmodule

// ----- rtl/drp_reply_match.sv -----
// Numeric and transparent reply matcher; routes unmatched bytes to the key parser.
// Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_reply_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  drp_pkg::t_action    i_action,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_reply_code,
    output drp_pkg::t_match_res o_res
);

    drp_pkg::t_wait r_wait, n_wait;
    logic [7:0]     r_code, n_code;
    logic           r_started, n_started;
    logic [2:0]     r_pfill, n_pfill;
    logic [1:0]     r_tfill, n_tfill;
    logic [31:0]    r_word, n_word;

    always_comb begin
        n_wait        = r_wait;
        n_code        = r_code;
        n_started     = r_started;
        n_pfill       = r_pfill;
        n_tfill       = r_tfill;
        n_word        = r_word;
        o_res.to_keys = 1'b0;
        o_res.kind    = drp_pkg::KIND_NONE;
        o_res.value   = 32'd0;

        unique case (i_action)
            drp_pkg::ACT_AWAIT_NUM: begin
                n_wait    = drp_pkg::WAIT_NUM;
                n_started = 1'b0;
                n_pfill   = 3'd0;
                n_tfill   = 2'd0;
            end
            drp_pkg::ACT_AWAIT_TRANS: begin
                n_wait    = drp_pkg::WAIT_TRANS;
                n_code    = i_reply_code;
                n_started = 1'b0;
                n_pfill   = 3'd0;
                n_tfill   = 2'd0;
            end
            drp_pkg::ACT_ABANDON: begin
                n_wait    = drp_pkg::WAIT_NONE;
                n_started = 1'b0;
                n_pfill   = 3'd0;
                n_tfill   = 2'd0;
            end
            default: begin
                unique case (r_wait)
                    drp_pkg::WAIT_NUM: begin
                        if (!r_started) begin
                            if (i_rx_byte == drp_pkg::HDR_NUM) begin
                                n_started = 1'b1;
                                n_pfill   = 3'd0;
                                n_tfill   = 2'd0;
                            end else begin
                                o_res.to_keys = 1'b1;
                            end
                        end else if (r_pfill < drp_pkg::PAYLOAD_BYTES) begin
                            // little-endian: byte lane = payload position
                            n_word[{r_pfill[1:0], 3'b000} +: 8] = i_rx_byte;
                            n_pfill = r_pfill + 3'd1;
                        end else if (i_rx_byte == drp_pkg::TERM_BYTE) begin
                            if (r_tfill >= drp_pkg::TERM_LAST) begin
                                o_res.kind  = drp_pkg::KIND_NUM_DONE;
                                o_res.value = r_word;
                                n_wait      = drp_pkg::WAIT_NONE;
                                n_started   = 1'b0;
                                n_pfill     = 3'd0;
                                n_tfill     = 2'd0;
                            end else begin
                                n_tfill = r_tfill + 2'd1;
                            end
                        end else begin
                            // broken terminator: restart, byte may be a new header
                            n_started = (i_rx_byte == drp_pkg::HDR_NUM);
                            n_pfill   = 3'd0;
                            n_tfill   = 2'd0;
                        end
                    end
                    drp_pkg::WAIT_TRANS: begin
                        if (!r_started) begin
                            if (i_rx_byte == r_code) begin
                                n_started = 1'b1;
                                n_tfill   = 2'd0;
                            end else begin
                                o_res.to_keys = 1'b1;
                            end
                        end else if (i_rx_byte == drp_pkg::TERM_BYTE) begin
                            if (r_tfill >= drp_pkg::TERM_LAST) begin
                                o_res.kind = drp_pkg::KIND_TRANS_DONE;
                                n_wait     = drp_pkg::WAIT_NONE;
                                n_started  = 1'b0;
                                n_pfill    = 3'd0;
                                n_tfill    = 2'd0;
                            end else begin
                                n_tfill = r_tfill + 2'd1;
                            end
                        end else begin
                            n_started = (i_rx_byte == r_code);
                            n_tfill   = 2'd0;
                        end
                    end
                    default: begin
                        n_wait        = drp_pkg::WAIT_NONE;
                        o_res.to_keys = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait    <= drp_pkg::WAIT_NONE;
            r_code    <= 8'd0;
            r_started <= 1'b0;
            r_pfill   <= 3'd0;
            r_tfill   <= 2'd0;
        end else if (i_step) begin
            r_wait    <= n_wait;
            r_code    <= n_code;
            r_started <= n_started;
            r_pfill   <= n_pfill;
            r_tfill   <= n_tfill;
        end
    end

    // payload lanes are all rewritten before a reply completes
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_word <= n_word;
        end
    end

endmodule

// ----- rtl/drp_checker.sv -----
// Port-level checks for display_reply_and_key_parser, attached by bind.
// Depends on drp_pkg and the top level's interface ports.
`timescale 1ns / 1ps

module drp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_result_kind,
    input logic [2:0]  i_event_code,
    input logic [1:0]  i_cycle_count,
    input logic [31:0] i_reply_value
);

    // no result can be pending right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_kind) &&
            $stable(i_event_code) && $stable(i_cycle_count) && $stable(i_reply_value))
        else $error("stalled result changed");

    // event fields only on key events
    a_event_on_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind != drp_pkg::KIND_KEY |->
            i_event_code == drp_pkg::EV_NONE && i_cycle_count == 2'd0)
        else $error("event fields set on non-key result");

    // cycle count only with set-cycles, and value only on numeric completion
    a_cyc_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_cycle_count == 2'd0 || i_event_code == drp_pkg::EV_SET_CYCLES) &&
            (i_reply_value == 32'd0 || i_result_kind == drp_pkg::KIND_NUM_DONE))
        else $error("cycle count or reply value out of place");

endmodule

bind display_reply_and_key_parser drp_checker u_drp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_kind (o_out.result_kind),
    .i_event_code  (o_out.event_code),
    .i_cycle_count (o_out.cycle_count),
    .i_reply_value (o_out.reply_value)
);

// ----- sim/drp_parse_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the display reply and key parser: predicts one result per
// accepted request and compares in order. Depends on drp_pkg and drp_if.

module drp_parse_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    drp_in_if    i_req,
    drp_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_key_events,
    output int   o_replies
);
    import drp_pkg::*;

    typedef struct packed {
        t_kind       kind;
        t_event      ev;
        logic [1:0]  cyc;
        logic [31:0] value;
    } parse_outcome_t;

    // Shadow of the parser state
    logic [7:0]  frame_buf [FRAME_LENGTH];
    logic [2:0]  frame_cnt;
    t_wait       wait_st;
    logic [7:0]  armed_code;
    logic        reply_seen;
    logic [2:0]  payload_cnt;
    logic [1:0]  term_cnt;
    logic [31:0] payload_acc;

    parse_outcome_t outcome_q [$];
    int fails = 0;
    int checked = 0;
    int key_events = 0;
    int replies = 0;

    function automatic void clear_matcher();
        reply_seen  = 1'b0;
        payload_cnt = '0;
        term_cnt    = '0;
        payload_acc = '0;
    endfunction

    function automatic void reset_state();
        foreach (frame_buf[i]) frame_buf[i] = '0;
        frame_cnt  = '0;
        wait_st    = WAIT_NONE;
        armed_code = '0;
        clear_matcher();
    endfunction

    // One byte into the key frame collector
    function automatic t_event key_step(input logic [7:0] b, output logic [1:0] cyc);
        cyc = '0;
        if (frame_cnt >= FRAME_LENGTH) frame_cnt = '0;
        if (frame_cnt == 0) begin
            if (b == ASCII_ONE || b == ASCII_THREE) begin
                cyc = (b == ASCII_ONE) ? 2'd1 : 2'd3;
                return EV_SET_CYCLES;
            end
            if (b == HDR_KEY) begin
                frame_buf[0] = b;
                frame_cnt    = 3'd1;
            end
            return EV_NONE;
        end
        // 0x55 mid-frame restarts the frame
        if (b == HDR_KEY) begin
            frame_buf[0] = b;
            frame_cnt    = 3'd1;
            return EV_NONE;
        end
        frame_buf[frame_cnt] = b;
        frame_cnt++;
        if (frame_cnt < FRAME_LENGTH) return EV_NONE;
        frame_cnt = '0;
        if (frame_buf[0] != HDR_KEY || frame_buf[2] != FILL_BYTE ||
            frame_buf[3] != FILL_BYTE || frame_buf[4] != TERM_BYTE ||
            frame_buf[5] != TERM_BYTE || frame_buf[FRAME_LAST] != TERM_BYTE)
            return EV_NONE;
        if (frame_buf[POS_ID] >= 8'(EV_START) && frame_buf[POS_ID] <= 8'(EV_FREQ))
            return t_event'(frame_buf[POS_ID][2:0]);
        return EV_NONE;
    endfunction

    function automatic parse_outcome_t parse_request(input t_action act,
                                                     input logic [7:0] b,
                                                     input logic [7:0] code);
        parse_outcome_t res;
        logic           go_keys;
        t_event         ev;
        logic [1:0]     cyc;
        res     = '0;
        go_keys = 1'b0;
        case (act)
            ACT_AWAIT_NUM: begin
                wait_st = WAIT_NUM;
                clear_matcher();
            end
            ACT_AWAIT_TRANS: begin
                wait_st    = WAIT_TRANS;
                armed_code = code;
                clear_matcher();
            end
            ACT_ABANDON: begin
                wait_st = WAIT_NONE;
                clear_matcher();
            end
            default: begin
                case (wait_st)
                    WAIT_NUM: begin
                        if (!reply_seen) begin
                            if (b == HDR_NUM) begin
                                clear_matcher();
                                reply_seen = 1'b1;
                            end else begin
                                go_keys = 1'b1;
                            end
                        end else if (payload_cnt < PAYLOAD_BYTES) begin
                            payload_acc |= 32'(b) << (8 * payload_cnt);
                            payload_cnt++;
                        end else if (b == TERM_BYTE) begin
                            if (term_cnt >= TERM_LAST) begin
                                res.kind  = KIND_NUM_DONE;
                                res.value = payload_acc;
                                wait_st   = WAIT_NONE;
                                clear_matcher();
                            end else begin
                                term_cnt++;
                            end
                        end else begin
                            // broken terminator: restart, 0x71 counts as a new header
                            clear_matcher();
                            reply_seen = (b == HDR_NUM);
                        end
                    end
                    WAIT_TRANS: begin
                        if (!reply_seen) begin
                            if (b == armed_code) begin
                                reply_seen = 1'b1;
                                term_cnt   = '0;
                            end else begin
                                go_keys = 1'b1;
                            end
                        end else if (b == TERM_BYTE) begin
                            if (term_cnt >= TERM_LAST) begin
                                res.kind = KIND_TRANS_DONE;
                                wait_st  = WAIT_NONE;
                                clear_matcher();
                            end else begin
                                term_cnt++;
                            end
                        end else begin
                            reply_seen = (b == armed_code);
                            term_cnt   = '0;
                        end
                    end
                    default: begin
                        wait_st = WAIT_NONE;
                        go_keys = 1'b1;
                    end
                endcase
            end
        endcase
        if (go_keys) begin
            ev = key_step(b, cyc);
            if (ev != EV_NONE) begin
                res.kind = KIND_KEY;
                res.ev   = ev;
                res.cyc  = cyc;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        parse_outcome_t want;
        if (!i_rst_n) begin
            reset_state();
            outcome_q.delete();
        end else begin
            // results first: a result can never belong to a request of the same edge
            if (i_res.valid && i_res.ready) begin
                if (outcome_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with no request pending: kind %0d event %0d cycles %0d value %08h",
                             $time, i_res.result_kind, i_res.event_code, i_res.cycle_count,
                             i_res.reply_value);
                end else begin
                    want = outcome_q.pop_front();
                    checked++;
                    if (want.kind == KIND_KEY) key_events++;
                    if (want.kind == KIND_NUM_DONE || want.kind == KIND_TRANS_DONE) replies++;
                    if (i_res.result_kind !== want.kind || i_res.event_code !== want.ev ||
                        i_res.cycle_count !== want.cyc || i_res.reply_value !== want.value) begin
                        fails++;
                        $display("%0t: mismatch: want kind %0d event %0d cycles %0d value %08h, got kind %0d event %0d cycles %0d value %08h",
                                 $time, want.kind, want.ev, want.cyc, want.value,
                                 i_res.result_kind, i_res.event_code, i_res.cycle_count,
                                 i_res.reply_value);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                outcome_q.push_back(parse_request(t_action'(i_req.action), i_req.rx_byte,
                                                  i_req.reply_code));
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_key_events <= key_events;
        o_replies    <= replies;
    end

endmodule

// ----- sim/display_reply_and_key_parser_tb.sv -----
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, request and result traffic, verdict.
// Depends on drp_pkg, drp_if, display_reply_and_key_parser and drp_parse_checker.

module display_reply_and_key_parser_tb;
    import drp_pkg::*;

    localparam int CLK_HALF       = 6;        // 12 ns period
    localparam int ITEM_TARGET    = 950;      // requests to offer in total
    localparam int HOLD_CYCLES    = 40;       // long result hold-off, fills the pipe
    localparam int TIMEOUT_CYCLES = 200_000;  // many times the slowest correct run

    // Transparent reply codes the display commonly sends
    localparam logic [7:0] CODE_OK   = 8'hFE;
    localparam logic [7:0] CODE_DONE = 8'hFD;

    // Ways a generated sequence departs from the clean form
    typedef enum int {
        FLT_NONE,
        FLT_BAD_BYTE,   // wrong byte in frame / broken reply terminator
        FLT_RESYNC,     // key frame restarted by a stray 0x55
        FLT_ABANDON,    // wait abandoned partway through a reply
        FLT_REARM       // wait re-armed partway through a reply
    } fault_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    drp_in_if  req_ch ();
    drp_out_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int key_events;
    int replies;

    int sent       = 0;     // requests accepted so far
    int idle_phase = 0;     // 0: sender 22 / receiver 69, 1: swapped, 2: no idling
    bit hold_ask   = 1'b0;  // asks the receiver for one long hold-off

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    display_reply_and_key_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    drp_parse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_key_events (key_events),
        .o_replies    (replies)
    );

    // Hard stop in case the handshake locks up
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding", TIMEOUT_CYCLES, pending);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure by phase, plus the long hold-off.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    initial begin
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_ask) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ask = 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >=
                                 ((idle_phase == 0) ? 69 : (idle_phase == 1) ? 22 : 0));
            end
        end
    end

    // Offer one request, with a random gap first; returns at the accepting edge.
    // valid is only lowered inside a gap, so it never toggles within one step.
    task automatic send_req(input t_action act, input logic [7:0] rx, input logic [7:0] code);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 22 : (idle_phase == 1) ? 69 : 0;
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.rx_byte    <= rx;
        req_ch.reply_code <= code;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        sent++;
    endtask

    // Received byte; reply_code is don't-care here, so keep it moving
    task automatic send_byte(input logic [7:0] b);
        send_req(ACT_RX_BYTE, b, 8'($urandom_range(255)));
    endtask

    // Stop offering until every predicted result has come back.
    // It waits on the clock before checking, so the count includes the request just accepted.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Byte biased toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] stray_byte(input logic [7:0] avoid);
        logic [7:0] b;
        b = pick_byte();
        if (b == avoid) b ^= 8'h01;
        return b;
    endfunction

    task automatic send_payload(input logic [31:0] value);
        int i;
        for (i = 0; i < 4; i++) send_byte(value[8 * i +: 8]);
    endtask

    // Key frame 55 id 00 00 FF FF FF, optionally corrupted or preceded by a
    // partial frame that the second 0x55 throws away
    task automatic key_frame_seq(input logic [7:0] id, input fault_t f);
        logic [7:0] frame [FRAME_LENGTH];
        int         n;
        int         i;
        frame = '{HDR_KEY, id, FILL_BYTE, FILL_BYTE, TERM_BYTE, TERM_BYTE, TERM_BYTE};
        if (f == FLT_BAD_BYTE) frame[$urandom_range(6, 2)] = pick_byte();
        if (f == FLT_RESYNC) begin
            send_byte(HDR_KEY);
            n = $urandom_range(3);
            for (i = 0; i < n; i++) send_byte(frame[i + 1]);
        end
        for (i = 0; i < FRAME_LENGTH; i++) send_byte(frame[i]);
    endtask

    // Numeric wait: arm, stray bytes for the key parser, 71 + payload + FF FF FF
    task automatic num_reply_seq(input logic [31:0] value, input int stray, input fault_t f);
        int         cut;
        logic [7:0] bad;
        send_req(ACT_AWAIT_NUM, 8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat (stray) send_byte(stray_byte(HDR_NUM));
        send_byte(HDR_NUM);
        send_payload(value);
        if (f != FLT_NONE) begin
            cut = $urandom_range(2);
            repeat (cut) send_byte(TERM_BYTE);
            case (f)
                FLT_ABANDON: send_req(ACT_ABANDON, 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
                FLT_REARM: begin
                    send_req(ACT_AWAIT_NUM, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    send_byte(HDR_NUM);
                    send_payload(value);
                end
                default: begin
                    // non-FF byte breaks the terminator; 0x71 doubles as new header
                    bad = $urandom_range(1) ? HDR_NUM : stray_byte(TERM_BYTE);
                    send_byte(bad);
                    if (bad != HDR_NUM) send_byte(HDR_NUM);
                    send_payload(value);
                end
            endcase
        end
        if (f != FLT_ABANDON) repeat (3) send_byte(TERM_BYTE);
    endtask

    // Transparent wait: arm with code, stray bytes, code + FF FF FF.
    // With code FF there is no way to break the terminator.
    task automatic trans_reply_seq(input logic [7:0] code, input int stray, input fault_t f);
        int         cut;
        logic [7:0] bad;
        send_req(ACT_AWAIT_TRANS, 8'($urandom_range(255)), code);
        repeat (stray) send_byte(stray_byte(code));
        send_byte(code);
        if (f != FLT_NONE && !(f == FLT_BAD_BYTE && code == TERM_BYTE)) begin
            cut = $urandom_range(2);
            repeat (cut) send_byte(TERM_BYTE);
            case (f)
                FLT_ABANDON: send_req(ACT_ABANDON, 8'($urandom_range(255)),
                                      8'($urandom_range(255)));
                FLT_REARM: begin
                    send_req(ACT_AWAIT_TRANS, 8'($urandom_range(255)), code);
                    send_byte(code);
                end
                default: begin
                    bad = $urandom_range(1) ? code : stray_byte(TERM_BYTE);
                    send_byte(bad);
                    if (bad != code) send_byte(code);
                end
            endcase
        end
        if (f != FLT_ABANDON) repeat (3) send_byte(TERM_BYTE);
    endtask

    // Stimulus and verdict
    initial begin
        int     pick;
        fault_t f;
        int     stray;
        logic [7:0] code;
        bit     held_early;
        bit     held_late;
        bit     drained_mid;

        held_early  = 1'b0;
        held_late   = 1'b0;
        drained_mid = 1'b0;

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_RX_BYTE;
        req_ch.rx_byte    <= '0;
        req_ch.reply_code <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: both ASCII set-cycles keys, a frequency frame restarted by
        // a second 0x55, an all-ones numeric reply, a transparent reply whose
        // code is FF itself, and an abandon with nothing armed
        send_byte(ASCII_ONE);
        send_byte(ASCII_THREE);
        key_frame_seq(8'(EV_FREQ), FLT_RESYNC);
        num_reply_seq(32'hFFFF_FFFF, 0, FLT_NONE);
        trans_reply_seq(TERM_BYTE, 0, FLT_NONE);
        send_req(ACT_ABANDON, 8'h00, 8'hFF);
        drain();

        // Random: mostly well-formed frames and replies with random content,
        // a quarter of them faulted, the rest ASCII keys and raw noise
        while (sent < ITEM_TARGET) begin
            idle_phase = (sent < 350) ? 0 : (sent < 700) ? 1 : 2;
            if (!held_early && sent >= 150) begin
                hold_ask   = 1'b1;
                held_early = 1'b1;
            end
            if (!held_late && sent >= 820) begin
                hold_ask  = 1'b1;
                held_late = 1'b1;
            end
            if (!drained_mid && sent >= 520) begin
                drain();
                drained_mid = 1'b1;
            end

            pick  = $urandom_range(99);
            f     = ($urandom_range(3) == 0) ? fault_t'($urandom_range(4, 1)) : FLT_NONE;
            stray = ($urandom_range(1) == 0) ? 0 : $urandom_range(3, 1);
            case ($urandom_range(3))
                0:       code = CODE_OK;
                1:       code = CODE_DONE;
                2:       code = TERM_BYTE;
                default: code = 8'($urandom_range(255));
            endcase

            if (pick < 25)
                key_frame_seq(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(3, 1)), f);
            else if (pick < 50)
                num_reply_seq({pick_byte(), pick_byte(), pick_byte(), pick_byte()}, stray, f);
            else if (pick < 72)
                trans_reply_seq(code, stray, f);
            else if (pick < 84)
                send_byte($urandom_range(1) ? ASCII_ONE : ASCII_THREE);
            else
                repeat ($urandom_range(4, 1))
                    send_req(t_action'($urandom_range(3)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
        end

        // Let everything come back, then keep the clock running so anything stray shows up
        drain();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results, %0d key events, %0d completed replies,",
                 sent, checked, key_events, replies);
        $display("under swapped idle mixes, a no-idle stretch, two long result stalls and full drains.");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures, %0d results outstanding", fail_count, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/drp_pkg.sv
rtl/drp_if.sv
rtl/drp_key_parser.sv
rtl/drp_reply_match.sv
rtl/display_reply_and_key_parser.sv
rtl/drp_checker.sv
sim/drp_parse_checker.sv
sim/display_reply_and_key_parser_tb.sv
